@@ rtl/owrs_pkg.sv @@
// ----------------------------------------------------------------------------
// owrs_pkg
// shared types and codes for the search rom engine: item and result layouts,
// action and status codes, rom length limits
// ----------------------------------------------------------------------------
package owrs_pkg;

  // action codes
  localparam logic [1:0] ACT_BEGIN = 2'd0;
  localparam logic [1:0] ACT_PAIR  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  // status codes
  localparam logic [2:0] ST_DIRECTION   = 3'd0;
  localparam logic [2:0] ST_FOUND       = 3'd1;
  localparam logic [2:0] ST_NO_PRESENCE = 3'd2;
  localparam logic [2:0] ST_NO_RESPONSE = 3'd3;
  localparam logic [2:0] ST_BAD_FAMILY  = 3'd4;
  localparam logic [2:0] ST_NO_MORE     = 3'd5;
  localparam logic [2:0] ST_READY       = 3'd6;
  localparam logic [2:0] ST_IGNORED     = 3'd7;

  // bit positions run from one; position past the last rom bit
  localparam logic [6:0] ROM_END_POS  = 7'd65;
  // positions below this lie in the family byte
  localparam logic [6:0] FAMILY_LIMIT = 7'd9;

  typedef struct packed {
    logic [1:0] action;
    logic       presence;
    logic       id_bit;
    logic       cmp_bit;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        direction;
    logic [63:0] found_rom;
    logic [3:0]  family_discrepancy;
  } rsp_t;

endpackage

@@ rtl/one_wire_rom_search_top.sv @@
// ----------------------------------------------------------------------------
// one_wire_rom_search_top
// search rom engine at the decision level: one direction decision per bit pair
// ----------------------------------------------------------------------------
// path: an item is held in the input register, then goes through the
//   decision logic into the result register
// throughput: one item per cycle, back to back, with a stalled result held
//   in the result register while the next item waits in the input register
// reset: synchronous rst clears the search state (rom image, discrepancy
//   positions, last-device and active flags, bit position 1) and both valid flags
// ----------------------------------------------------------------------------
module one_wire_rom_search_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  owrs_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output owrs_pkg::rsp_t  rsp
);
  import owrs_pkg::*;

  // input register
  logic s1_valid;
  req_t s1_req;

  // search state
  logic [63:0] rom_bits;
  logic [6:0]  last_discrepancy_pos;
  logic [3:0]  family_discrepancy_pos;
  logic        last_device_seen;
  logic [6:0]  bit_position;
  logic [6:0]  zero_branch_pos;
  logic        search_active;

  logic [63:0] rom_bits_next;
  logic [6:0]  last_discrepancy_pos_next;
  logic [3:0]  family_discrepancy_pos_next;
  logic        last_device_seen_next;
  logic [6:0]  bit_position_next;
  logic [6:0]  zero_branch_pos_next;
  logic        search_active_next;

  // decision results
  logic [2:0]  status;
  logic        dir;
  logic [63:0] rom_out;
  logic        do_clear;
  logic [5:0]  idx;

  // flow control: the result register frees up when empty or taken
  logic advance;
  logic s1_load;

  assign advance   = !rsp_valid || !rsp_stall;
  assign s1_load   = !s1_valid || advance;
  assign req_stall = !s1_load;

  always_comb begin
    rom_bits_next               = rom_bits;
    last_discrepancy_pos_next   = last_discrepancy_pos;
    family_discrepancy_pos_next = family_discrepancy_pos;
    last_device_seen_next       = last_device_seen;
    bit_position_next           = bit_position;
    zero_branch_pos_next        = zero_branch_pos;
    search_active_next          = search_active;
    status   = ST_IGNORED;
    dir      = 1'b0;
    rom_out  = '0;
    do_clear = 1'b0;
    // rom bit index of the current position, wraps like the position does
    idx      = 6'(bit_position - 7'd1);

    unique case (s1_req.action)
      ACT_BEGIN: begin
        if (last_device_seen) begin
          do_clear = 1'b1;
          status   = ST_NO_MORE;
        end else if (!s1_req.presence) begin
          do_clear = 1'b1;
          status   = ST_NO_PRESENCE;
        end else begin
          // start or restart a pass, discrepancy history kept
          bit_position_next    = 7'd1;
          zero_branch_pos_next = 7'd0;
          search_active_next   = 1'b1;
          status               = ST_READY;
        end
      end
      ACT_PAIR: begin
        if (search_active) begin
          if (s1_req.id_bit && s1_req.cmp_bit) begin
            // nobody drove the bus low in either slot
            do_clear = 1'b1;
            status   = ST_NO_RESPONSE;
          end else begin
            if (s1_req.id_bit != s1_req.cmp_bit) begin
              // all remaining devices agree on this bit
              dir = s1_req.id_bit;
            end else begin
              // discrepancy: follow the old path, take one at the old fork,
              // zero past it
              if (bit_position < last_discrepancy_pos) begin
                dir = rom_bits[idx];
              end else begin
                dir = (bit_position == last_discrepancy_pos);
              end
              if (!dir) begin
                zero_branch_pos_next = bit_position;
                if (bit_position < FAMILY_LIMIT) begin
                  family_discrepancy_pos_next = bit_position[3:0];
                end
              end
            end
            rom_bits_next[idx] = dir;
            bit_position_next  = 7'(bit_position + 7'd1);
            status             = ST_DIRECTION;
            if (bit_position_next >= ROM_END_POS) begin
              // last bit of the rom: close the pass
              search_active_next        = 1'b0;
              last_discrepancy_pos_next = zero_branch_pos_next;
              if (zero_branch_pos_next == 7'd0) begin
                last_device_seen_next = 1'b1;
              end
              if (rom_bits_next[7:0] == 8'd0) begin
                do_clear = 1'b1;
                status   = ST_BAD_FAMILY;
              end else begin
                rom_out = rom_bits_next;
                status  = ST_FOUND;
              end
            end
          end
        end
      end
      ACT_CLEAR: begin
        do_clear = 1'b1;
        status   = ST_READY;
      end
      default: begin
        // unused action code, nothing changes
      end
    endcase

    if (do_clear) begin
      rom_bits_next               = '0;
      last_discrepancy_pos_next   = '0;
      family_discrepancy_pos_next = '0;
      last_device_seen_next       = 1'b0;
      bit_position_next           = 7'd1;
      zero_branch_pos_next        = '0;
      search_active_next          = 1'b0;
    end
  end

  // input register: takes a transfer whenever the slot is free or moving on
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= req_valid;
    end
    if (s1_load) begin
      s1_req <= req;
    end
  end

  // search state moves only when an item is decided
  always_ff @(posedge clk) begin
    if (rst) begin
      rom_bits               <= '0;
      last_discrepancy_pos   <= '0;
      family_discrepancy_pos <= '0;
      last_device_seen       <= 1'b0;
      bit_position           <= 7'd1;
      zero_branch_pos        <= '0;
      search_active          <= 1'b0;
    end else if (s1_valid && advance) begin
      rom_bits               <= rom_bits_next;
      last_discrepancy_pos   <= last_discrepancy_pos_next;
      family_discrepancy_pos <= family_discrepancy_pos_next;
      last_device_seen       <= last_device_seen_next;
      bit_position           <= bit_position_next;
      zero_branch_pos        <= zero_branch_pos_next;
      search_active          <= search_active_next;
    end
  end

  // result register: holds while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= s1_valid;
    end
    if (s1_valid && advance) begin
      rsp.status             <= status;
      rsp.direction          <= dir;
      rsp.found_rom          <= rom_out;
      rsp.family_discrepancy <= family_discrepancy_pos_next;
    end
  end

endmodule

@@ rtl/owrs_checker.sv @@
// ----------------------------------------------------------------------------
// owrs_checker
// port-level checks on the result channel of the search rom engine
// ----------------------------------------------------------------------------
module owrs_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            rsp_valid,
  input  logic            rsp_stall,
  input  owrs_pkg::rsp_t  rsp
);
  import owrs_pkg::*;

  // a stalled result stays offered
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its value
  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> $stable(rsp))
    else $error("result changed while stalled");

  // only a found result carries a rom code
  a_rom_only_found: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_FOUND |-> rsp.found_rom == 64'd0)
    else $error("rom code on a result that is not found");

  // direction is zero unless a bit is to be written
  a_dir_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_DIRECTION && rsp.status != ST_FOUND &&
    rsp.status != ST_BAD_FAMILY |-> !rsp.direction)
    else $error("direction set on a status without a write");

  // family discrepancy lies in the family byte and is gone on a bad-family result
  a_family_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.family_discrepancy <= 4'd8 &&
    (rsp.status != ST_BAD_FAMILY || rsp.family_discrepancy == 4'd0))
    else $error("family discrepancy out of range");

endmodule

bind one_wire_rom_search_top owrs_checker u_owrs_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
